### design/fwt_pkg.sv
// Package with the shared types and codes of the queue with take by type.
`default_nettype none

package fwt_pkg;

    // Action codes carried by an input item.
    typedef enum logic [2:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_TAKE  = 3'd2,
        ACT_PEEK  = 3'd3,
        ACT_CLEAR = 3'd4
    } action_t;

    // Register index of the generic type limit.
    localparam logic REG_GENERIC_LIMIT = 1'b0;

    // One stored entry: handle, type and the block-number-zero flag.
    typedef struct packed {
        logic [15:0] handle;
        logic [7:0]  btype;
        logic        zflag;
    } entry_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;    // write the pushed entry into the cell at the tail
        logic shift;   // every cell takes its right neighbor, head leaves
        logic rotate;  // shift, with the head wrapping to the tail cell
    } cell_ctl_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } fsm_state_t;

endpackage

`default_nettype wire

### design/fifo_with_take_by_type_top.sv
// Top level of the bounded item queue with push, pop, peek, clear and take by type.
//
//   Channel   Signals                                          Direction
//   -------   ----------------------------------------------   ---------
//   in        in_valid/in_ready, action, item_handle, ...      sink
//   out       out_valid/out_ready, found, out_handle, ...      source
//   apb       psel, penable, pwrite, paddr, pwdata, prdata     slave
//
// Push, pop, peek, clear: the result register loads in the cycle of acceptance.
// Take by type: in SCAN the chain rotates one place per cycle so every entry
// passes the head cell once; DONE loads the result once the output is free.
// Take on an empty queue skips the scan and loads its result like the others.
// One item is in work at a time; a waiting result stalls the next item only
// when it is still not taken at the cycle its successor would be written.
// Reset clears the entry count, the controller and the limit register.
`default_nettype none

module fifo_with_take_by_type_top
    import fwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] item_handle,
    input  wire logic [7:0]  item_type,
    input  wire logic [15:0] block_number,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             found,
    output logic [15:0]      out_handle,
    output logic [7:0]       out_type,
    output logic [4:0]       queue_count,
    output logic             overflow,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

    // Configuration register.
    logic [7:0] limit_reg;

    // Controller and queue bookkeeping.
    fsm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] step_reg;
    logic [7:0]       seek_type_reg;
    logic             seek_any_reg;
    logic             hit_reg;
    logic [15:0]      hit_handle_reg;
    logic [7:0]       hit_type_reg;

    // Result register.
    logic             out_valid_reg;
    logic             found_reg;
    logic [15:0]      handle_reg;
    logic [7:0]       type_reg;
    logic [CNT_W-1:0] qcount_reg;
    logic             overflow_reg;

    // Entry chain.
    entry_t    cell_q [QUEUE_DEPTH];
    entry_t    push_entry;
    entry_t    head;
    cell_ctl_t ctl;

    logic    accept;
    logic    out_free;
    logic    match;
    logic    load_out;
    action_t act;
    logic [31:0] qcount_ext;

    assign act      = action_t'(action);
    assign head     = cell_q[0];
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign push_entry.handle = item_handle;
    assign push_entry.btype  = item_type;
    assign push_entry.zflag  = (block_number == 16'd0);

    // Head matches the sought type during a scan, first match only.
    assign match = !hit_reg && (head.btype == seek_type_reg) &&
                   (seek_any_reg || head.zflag);

    // The chain of cells, head at index zero.
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        entry_t right;
        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign right = cell_q[0];
        end
        else
        begin : g_mid
            assign right = cell_q[g+1];
        end
        fwt_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .count       (count_reg),
            .push_entry  (push_entry),
            .right_entry (right),
            .head_entry  (cell_q[0]),
            .entry       (cell_q[g])
        );
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (act == ACT_TAKE) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == ONE_CNT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs: chain commands, input ready and result load.
    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (act == ACT_PUSH)
                    begin
                        ctl.push = (count_reg != FULL_CNT);
                    end
                    if (act == ACT_POP)
                    begin
                        ctl.shift = (count_reg != '0);
                    end
                    load_out = !((act == ACT_TAKE) && (count_reg != '0));
                end
            end
            ST_SCAN:
            begin
                ctl.shift  = match;
                ctl.rotate = !match;
            end
            ST_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // Controller and queue registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            step_reg  <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && accept)
            begin
                case (act)
                    ACT_PUSH:
                    begin
                        if (count_reg != FULL_CNT)
                        begin
                            count_reg <= count_reg + ONE_CNT;
                        end
                    end
                    ACT_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            count_reg <= count_reg - ONE_CNT;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
                step_reg <= count_reg;
                hit_reg  <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                step_reg <= step_reg - ONE_CNT;
                if (match)
                begin
                    hit_reg   <= 1'b1;
                    count_reg <= count_reg - ONE_CNT;
                end
            end
        end
    end

    // Scan payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            seek_type_reg  <= item_type;
            seek_any_reg   <= (item_type >= limit_reg);
            hit_handle_reg <= '0;
            hit_type_reg   <= '0;
        end
        else if (state_reg == ST_SCAN && match)
        begin
            hit_handle_reg <= head.handle;
            hit_type_reg   <= head.btype;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (state_reg == ST_DONE)
            begin
                found_reg    <= hit_reg;
                handle_reg   <= hit_handle_reg;
                type_reg     <= hit_type_reg;
                qcount_reg   <= count_reg;
                overflow_reg <= 1'b0;
            end
            else
            begin
                found_reg    <= 1'b0;
                handle_reg   <= '0;
                type_reg     <= '0;
                qcount_reg   <= count_reg;
                overflow_reg <= 1'b0;
                case (act)
                    ACT_PUSH:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        else
                        begin
                            qcount_reg <= count_reg + ONE_CNT;
                        end
                    end
                    ACT_POP, ACT_PEEK:
                    begin
                        if (count_reg != '0)
                        begin
                            found_reg  <= 1'b1;
                            handle_reg <= head.handle;
                            type_reg   <= head.btype;
                            if (act == ACT_POP)
                            begin
                                qcount_reg <= count_reg - ONE_CNT;
                            end
                        end
                    end
                    ACT_CLEAR:
                    begin
                        qcount_reg <= '0;
                    end
                    default:
                    begin
                        qcount_reg <= count_reg;
                    end
                endcase
            end
        end
    end

    assign qcount_ext  = 32'(qcount_reg);
    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign out_handle  = handle_reg;
    assign out_type    = type_reg;
    assign queue_count = qcount_ext[4:0];
    assign overflow    = overflow_reg;

    // Configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
        end
        else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_GENERIC_LIMIT))
        begin
            limit_reg <= pwdata[7:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GENERIC_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    // The entry count never passes the queue depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above queue depth");

    // A pop on a non-empty queue removes exactly one entry.
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (act == ACT_POP) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - ONE_CNT))
        else $error("pop did not remove one entry");

    // A scan never adds entries.
    a_scan_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (count_reg <= $past(count_reg)))
        else $error("entry count grew during a scan");

    // A result never reports both an entry and a dropped push.
    a_ovf_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(overflow_reg && found_reg))
        else $error("overflow and found set together");

endmodule

`default_nettype wire

### design/fwt_cell.sv
// One cell of the entry chain: holds one entry and moves it toward the head.
`default_nettype none

module fwt_cell
    import fwt_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  wire logic             clk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [CNT_W-1:0] count,
    input  wire entry_t           push_entry,
    input  wire entry_t           right_entry,
    input  wire entry_t           head_entry,
    output entry_t                entry
);

    localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NEXT = CNT_W'(IDX + 1);

    entry_t entry_reg;
    entry_t entry_next;

    // Select what this cell holds after the edge.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.push && (count == MY_POS))
        begin
            entry_next = push_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = right_entry;
        end
        else if (ctl.rotate)
        begin
            // The last occupied cell receives the old head.
            entry_next = (count == MY_NEXT) ? head_entry : right_entry;
        end
    end

    // Entry payload carries no reset.
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### verif/fwt_checker.sv
// Checker for the queue with take by type: mirrors the queue, predicts each result and compares.
`timescale 1ns / 100ps

module fwt_checker
    import fwt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] item_handle,
    input  wire logic [7:0]  item_type,
    input  wire logic [15:0] block_number,

    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic        found,
    input  wire logic [15:0] out_handle,
    input  wire logic [7:0]  out_type,
    input  wire logic [4:0]  queue_count,
    input  wire logic        overflow,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,

    output int               mismatch_count,
    output int               pending_results
);

    localparam logic [2:0] LIMIT_ADDR  = {REG_GENERIC_LIMIT, 2'b00};
    localparam int         PRINT_LIMIT = 100;

    // Fields of one result item as the block should present them.
    typedef struct packed {
        logic        found;
        logic [15:0] handle;
        logic [7:0]  btype;
        logic [4:0]  count;
        logic        overflow;
    } queue_result_t;

    // Shadow copy of the queue contents and of the limit register.
    entry_t        shadow_entries [QUEUE_DEPTH];
    int            shadow_count  = 0;
    logic [7:0]    shadow_limit  = 8'd0;
    queue_result_t expected_results [$];
    int            err_total     = 0;
    int            pending_total = 0;
    int            results_seen  = 0;

    assign mismatch_count  = err_total;
    assign pending_results = pending_total;

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        if (err_total < PRINT_LIMIT)
            $display("%0t: result %0d: %s", $time, results_seen, what);
        err_total++;
    endtask

    // Applies one accepted item to the shadow queue and queues its result.
    task automatic apply_queue_action(input logic [2:0]  act,
                                      input logic [15:0] hdl,
                                      input logic [7:0]  typ,
                                      input logic [15:0] num);
        queue_result_t res;
        int            pos;
        int            i;
        res = '0;
        pos = -1;
        case (act)
            ACT_PUSH:
            begin
                if (shadow_count < QUEUE_DEPTH)
                begin
                    shadow_entries[shadow_count] = '{handle: hdl, btype: typ,
                                                     zflag: (num == 16'd0)};
                    shadow_count++;
                end
                else
                begin
                    res.overflow = 1'b1;
                end
            end
            ACT_POP, ACT_PEEK:
            begin
                if (shadow_count > 0)
                begin
                    res.found  = 1'b1;
                    res.handle = shadow_entries[0].handle;
                    res.btype  = shadow_entries[0].btype;
                    if (act == ACT_POP)
                        pos = 0;
                end
            end
            ACT_TAKE:
            begin
                // Oldest match wins; the zero test is waived at or above the limit.
                for (i = 0; i < shadow_count; i++)
                begin
                    if (pos < 0 && shadow_entries[i].btype == typ &&
                        (typ >= shadow_limit || shadow_entries[i].zflag))
                    begin
                        pos        = i;
                        res.found  = 1'b1;
                        res.handle = shadow_entries[i].handle;
                        res.btype  = shadow_entries[i].btype;
                    end
                end
            end
            ACT_CLEAR:
            begin
                shadow_count = 0;
            end
            default:
            begin
            end
        endcase

        // Close the gap left by a removed entry, keeping the order.
        if (pos >= 0)
        begin
            for (i = pos; i + 1 < shadow_count; i++)
                shadow_entries[i] = shadow_entries[i + 1];
            shadow_count--;
        end
        res.count = 5'(shadow_count);
        expected_results.push_back(res);
    endtask

    // Compares one accepted result item with the oldest expectation.
    task automatic check_result();
        queue_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result item with no item waiting for it");
            return;
        end
        want = expected_results.pop_front();
        if (found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
        if (out_handle !== want.handle)
            report_mismatch($sformatf("out_handle %h, expected %h", out_handle, want.handle));
        if (out_type !== want.btype)
            report_mismatch($sformatf("out_type %h, expected %h", out_type, want.btype));
        if (queue_count !== want.count)
            report_mismatch($sformatf("queue_count %0d, expected %0d", queue_count,
                                      want.count));
        if (overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b", overflow,
                                      want.overflow));
    endtask

    // Watch the register port and both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_count = 0;
            shadow_limit = 8'd0;
            expected_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
                shadow_limit = pwdata[7:0];
            if (in_valid && in_ready)
                apply_queue_action(action, item_handle, item_type, block_number);
            if (out_valid && out_ready)
                check_result();
        end
        pending_total = expected_results.size();
    end

endmodule

### verif/tb_fifo_with_take_by_type_top.sv
// Testbench top for the queue with take by type: directed and random items, verdict.
`timescale 1ns / 100ps

module tb_fifo_with_take_by_type_top;
    import fwt_pkg::*;

    localparam int         QUEUE_DEPTH     = 16;
    localparam logic [2:0] LIMIT_ADDR      = {REG_GENERIC_LIMIT, 2'b00};
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
    localparam int         PHASE_ITEMS     = 340;
    localparam int         SEGMENT_ITEMS   = 24;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         SETTLE_CYCLES   = 2 * QUEUE_DEPTH;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic [2:0]  action       = ACT_PUSH;
    logic [15:0] item_handle  = 16'd0;
    logic [7:0]  item_type    = 8'd0;
    logic [15:0] block_number = 16'd0;
    logic        out_ready    = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = 3'd0;
    logic [31:0] pwdata       = 32'd0;

    logic        in_ready;
    logic        out_valid;
    logic        found;
    logic [15:0] out_handle;
    logic [7:0]  out_type;
    logic [4:0]  queue_count;
    logic        overflow;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_results;

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 30;
    int          hold_request      = 0;
    logic [7:0]  active_limit      = 8'd0;

    fifo_with_take_by_type_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .item_handle  (item_handle),
        .item_type    (item_type),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .out_handle   (out_handle),
        .out_type     (out_type),
        .queue_count  (queue_count),
        .overflow     (overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    fwt_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) queue_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .item_handle     (item_handle),
        .item_type       (item_type),
        .block_number    (block_number),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .out_handle      (out_handle),
        .out_type        (out_type),
        .queue_count     (queue_count),
        .overflow        (overflow),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("** fifo_with_take_by_type_top: FAILED **");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin : receiver_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Offers one item, after a random gap, and waits until it is accepted.
    task automatic send_item(input logic [2:0]  act,
                             input logic [15:0] hdl,
                             input logic [7:0]  typ,
                             input logic [15:0] num);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid     <= 1'b1;
        action       <= act;
        item_handle  <= hdl;
        item_type    <= typ;
        block_number <= num;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stops offering items until every expected result item has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    // Writes the generic type limit through a setup and an access phase.
    task automatic write_limit(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= {24'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        active_limit = value;
    endtask

    // Types cluster around the limit so that takes find matches on both sides of it.
    function automatic logic [7:0] pick_type(input logic [7:0] limit);
        int r;
        r = $urandom_range(9);
        if (r < 3)
            return limit;
        else if (r < 6)
            return limit - 8'd1;
        else if (r == 6)
            return 8'd0;
        else if (r == 7)
            return 8'hFF;
        else
            return 8'($urandom());
    endfunction

    // One random item; a filling segment favors pushes, a draining one removals.
    task automatic send_random_item(input bit filling);
        int          r;
        logic [2:0]  act;
        logic [15:0] num;
        r = $urandom_range(99);
        if (r < (filling ? 65 : 30))
            act = ACT_PUSH;
        else if (r < (filling ? 72 : 45))
            act = ACT_POP;
        else if (r < (filling ? 87 : 80))
            act = ACT_TAKE;
        else if (r < (filling ? 94 : 95))
            act = ACT_PEEK;
        else if (r < 97)
            act = ACT_CLEAR;
        else
            act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        num = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom());
        send_item(act, 16'($urandom()), pick_type(active_limit), num);
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        int  k;
        int  phase;
        int  n;
        bit  filling;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items around a limit in the middle of the type range.
        write_limit(8'h80);
        send_item(ACT_POP,  16'h0000, 8'h10, 16'h0000);
        send_item(ACT_PEEK, 16'h0000, 8'h10, 16'h0000);
        send_item(ACT_TAKE, 16'h0000, 8'h10, 16'h0000);

        // Fill the queue; the first four entries exercise the take rules.
        send_item(ACT_PUSH, 16'h0000, 8'h10, 16'h0005);
        send_item(ACT_PUSH, 16'hFFFF, 8'h10, 16'h0000);
        send_item(ACT_PUSH, 16'h1234, 8'hFF, 16'hFFFF);
        send_item(ACT_PUSH, 16'hABCD, 8'h80, 16'h0007);
        for (k = 0; k < QUEUE_DEPTH - 4; k++)
            send_item(ACT_PUSH, 16'($urandom()), 8'h20 + 8'(k), 16'(k));

        // A push to the full queue is dropped.
        send_item(ACT_PUSH, 16'h5555, 8'h10, 16'h0000);

        // Below the limit a nonzero block number is skipped, then nothing matches.
        send_item(ACT_TAKE, 16'h0000, 8'h10, 16'h0000);
        send_item(ACT_TAKE, 16'h0000, 8'h10, 16'h0000);

        // Above and at the limit the zero test is waived.
        send_item(ACT_TAKE, 16'h0000, 8'hFF, 16'h0000);
        send_item(ACT_TAKE, 16'h0000, 8'h80, 16'h0000);

        // Handle zero at the head, a spare action code, then clear.
        send_item(ACT_PEEK, 16'hFFFF, 8'h00, 16'hFFFF);
        send_item(ACT_POP,  16'hFFFF, 8'h00, 16'hFFFF);
        send_item(ACT_SPARE_LAST, 16'hFFFF, 8'hFF, 16'hFFFF);
        send_item(ACT_CLEAR, 16'hFFFF, 8'hFF, 16'hFFFF);
        wait_for_drain();

        // Random phases with different idling and limit settings.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct   = 20;
                    receiver_idle_pct = 74;
                    write_limit(8'h00);
                end
                1:
                begin
                    sender_idle_pct   = 74;
                    receiver_idle_pct = 20;
                    write_limit(8'hFF);
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                    write_limit(8'($urandom_range(1, 254)));
                end
            endcase
            filling = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % SEGMENT_ITEMS == 0)
                    filling = ($urandom_range(1) == 1);
                // The receiver holds off while items keep coming.
                if (phase == 0 && n == 100)
                    hold_request = HOLD_CYCLES;
                // The sender waits until all results are back.
                if (phase == 1 && n == 150)
                    wait_for_drain();
                send_random_item(filling);
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("** fifo_with_take_by_type_top: PASSED **");
        else
            $display("** fifo_with_take_by_type_top: FAILED **");
        $finish;
    end

endmodule
